[rtl/ekd_pkg.sv]
// ----------------------------------------------------------------------------
// ekd_pkg
// types, key codes and decode helpers for the escape key decoder
// ----------------------------------------------------------------------------
package ekd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ESC,
    PH_SEQ,
    PH_DIGIT
  } phase_t;

  typedef enum logic [0:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_reg_t;

  localparam logic [7:0] ESC_BYTE   = 8'h1b;
  localparam logic [7:0] CTRL_MASK  = 8'h1f;
  localparam logic [7:0] CHR_BRACK  = 8'h5b;
  localparam logic [7:0] CHR_O      = 8'h4f;
  localparam logic [7:0] CHR_TILDE  = 8'h7e;
  localparam logic [7:0] CHR_Q      = 8'h71;
  localparam logic [7:0] CTRL_Q     = CHR_Q & CTRL_MASK;

  localparam logic [8:0] KEY_ESC    = 9'd27;
  localparam logic [8:0] KEY_LEFT   = 9'd256;
  localparam logic [8:0] KEY_RIGHT  = 9'd257;
  localparam logic [8:0] KEY_UP     = 9'd258;
  localparam logic [8:0] KEY_DOWN   = 9'd259;
  localparam logic [8:0] KEY_DEL    = 9'd260;
  localparam logic [8:0] KEY_HOME   = 9'd261;
  localparam logic [8:0] KEY_END    = 9'd262;
  localparam logic [8:0] KEY_PGUP   = 9'd263;
  localparam logic [8:0] KEY_PGDN   = 9'd264;

  localparam logic [9:0] ROWS_RESET = 10'd24;
  localparam logic [9:0] COLS_RESET = 10'd80;

  function automatic logic [8:0] letter_key(input logic [7:0] b, input logic arrows);
    logic [8:0] k;
    k = KEY_ESC;
    if (arrows && b == 8'h41) k = KEY_UP;
    else if (arrows && b == 8'h42) k = KEY_DOWN;
    else if (arrows && b == 8'h43) k = KEY_RIGHT;
    else if (arrows && b == 8'h44) k = KEY_LEFT;
    else if (b == 8'h48) k = KEY_HOME;
    else if (b == 8'h46) k = KEY_END;
    return k;
  endfunction

  function automatic logic [8:0] digit_key(input logic [7:0] d);
    logic [8:0] k;
    case (d)
      8'h31, 8'h37: k = KEY_HOME;
      8'h34, 8'h38: k = KEY_END;
      8'h33:        k = KEY_DEL;
      8'h35:        k = KEY_PGUP;
      8'h36:        k = KEY_PGDN;
      default:      k = KEY_ESC;
    endcase
    return k;
  endfunction

  function automatic logic [9:0] step_down(input logic [9:0] v, input logic [9:0] amt);
    return (v >= amt) ? v - amt : 10'd0;
  endfunction

  function automatic logic [9:0] step_up(input logic [9:0] v, input logic [9:0] amt,
                                         input logic [9:0] last);
    logic [10:0] n;
    n = {1'b0, v} + {1'b0, amt};
    if (v >= last) return v;
    return (n > {1'b0, last}) ? last : n[9:0];
  endfunction

endpackage

[rtl/escape_key_decoder_cursor_unit.sv]
// ----------------------------------------------------------------------------
// escape_key_decoder_cursor_unit
// decodes terminal bytes and escape sequences into keys and tracks a cursor
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one request per cycle unless
// stalled: a received byte or a read timeout. Bytes that belong to an escape
// sequence produce no result; a completed, unknown or timed-out sequence
// produces one key. Result channel (out_valid/out_stall) carries the key code,
// the cursor column and row after the key, and the control-Q quit flag.
// A request passes an input register, is decoded against the parser and
// cursor state combinationally and lands in the result register. One
// request per cycle is taken as long as the result register drains; the
// decode/cursor update is the single stage that sets this rate.
// When the receiver stalls, the result holds and the input register keeps
// taking requests that yield no result; a request that yields a result waits
// in the input register and in_stall rises.
// Screen size is written through the APB port (rows at 0x0, cols at 0x4).
// Reset empties both stages, sets the parser idle, the cursor to 0,0 and the
// screen to 24 rows by 80 columns.
// ----------------------------------------------------------------------------
module escape_key_decoder_cursor_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [7:0] in_in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [8:0] out_key_code,
  output logic [9:0] out_cursor_col,
  output logic [9:0] out_cursor_row,
  output logic       out_quit,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);
  import ekd_pkg::*;

  logic       s1_valid_r;
  logic       s1_cmd_r;
  logic [7:0] s1_byte_r;
  phase_t     phase_r, phase_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] digit_r, digit_nxt;
  logic [9:0] col_r, col_nxt;
  logic [9:0] row_r, row_nxt;
  logic [9:0] rows_r, cols_r;
  logic       out_valid_r;
  logic [8:0] key_r;
  logic [9:0] ocol_r, orow_r;
  logic       quit_r;

  logic       has_res;
  logic [8:0] key;
  logic [9:0] rows_eff, cols_eff;
  logic       out_free, s1_go;
  logic       cfg_wr;
  cfg_reg_t   cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[2]);
  assign prdata  = {22'd0, (cfg_sel == CFG_COLS) ? cols_r : rows_r};

  assign rows_eff = (rows_r == 10'd0) ? 10'd1 : rows_r;
  assign cols_eff = (cols_r == 10'd0) ? 10'd1 : cols_r;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!has_res || out_free);
  assign in_stall = s1_valid_r && !s1_go;

  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    digit_nxt = digit_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    has_res   = 1'b0;
    key       = KEY_ESC;
    case (phase_r)
      PH_ESC: begin
        if (s1_cmd_r) begin
          has_res = 1'b1;
        end else begin
          first_nxt = s1_byte_r;
          phase_nxt = PH_SEQ;
        end
      end
      PH_SEQ: begin
        if (s1_cmd_r) begin
          has_res = 1'b1;
        end else if (first_r == CHR_BRACK && s1_byte_r inside {[8'h30:8'h39]}) begin
          digit_nxt = s1_byte_r;
          phase_nxt = PH_DIGIT;
        end else begin
          has_res = 1'b1;
          if (first_r == CHR_BRACK) key = letter_key(s1_byte_r, 1'b1);
          else if (first_r == CHR_O) key = letter_key(s1_byte_r, 1'b0);
        end
      end
      PH_DIGIT: begin
        has_res = 1'b1;
        if (!s1_cmd_r && s1_byte_r == CHR_TILDE) key = digit_key(digit_r);
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (!s1_cmd_r) begin
          if (s1_byte_r == ESC_BYTE) begin
            phase_nxt = PH_ESC;
          end else begin
            has_res = 1'b1;
            key     = {1'b0, s1_byte_r};
          end
        end
      end
    endcase
    if (has_res) begin
      phase_nxt = PH_IDLE;
      case (key)
        KEY_LEFT:  col_nxt = step_down(col_r, 10'd1);
        KEY_RIGHT: col_nxt = step_up(col_r, 10'd1, cols_eff - 10'd1);
        KEY_UP:    row_nxt = step_down(row_r, 10'd1);
        KEY_DOWN:  row_nxt = step_up(row_r, 10'd1, rows_eff - 10'd1);
        KEY_PGUP:  row_nxt = step_down(row_r, {2'd0, rows_eff[9:2]});
        KEY_PGDN:  row_nxt = step_up(row_r, {2'd0, rows_eff[9:2]}, rows_eff - 10'd1);
        KEY_HOME:  col_nxt = step_down(col_r, {2'd0, cols_eff[9:2]});
        KEY_END:   col_nxt = step_up(col_r, {2'd0, cols_eff[9:2]}, cols_eff - 10'd1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RESET;
      cols_r <= COLS_RESET;
    end else if (cfg_wr) begin
      if (cfg_sel == CFG_COLS) cols_r <= pwdata[9:0];
      else rows_r <= pwdata[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd_r  <= in_command;
      s1_byte_r <= in_in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      first_r <= 8'd0;
      digit_r <= 8'd0;
      col_r   <= 10'd0;
      row_r   <= 10'd0;
    end else if (s1_go) begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      digit_r <= digit_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_go && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_go && has_res) begin
      key_r  <= key;
      ocol_r <= col_nxt;
      orow_r <= row_nxt;
      quit_r <= (key == {1'b0, CTRL_Q});
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_code   = key_r;
  assign out_cursor_col = ocol_r;
  assign out_cursor_row = orow_r;
  assign out_quit       = quit_r;

endmodule

[rtl/ekd_checker.sv]
// ----------------------------------------------------------------------------
// ekd_checker
// port-level checks for the escape key decoder
// ----------------------------------------------------------------------------
module ekd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [8:0] out_key_code,
  input logic [9:0] out_cursor_col,
  input logic [9:0] out_cursor_row,
  input logic       out_quit
);
  import ekd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key_code)
      && $stable(out_cursor_col) && $stable(out_cursor_row))
    else $error("stalled result changed");

  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_key_code <= KEY_PGDN)
    else $error("key code out of range");

  a_quit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_quit == (out_key_code == {1'b0, CTRL_Q})))
    else $error("quit flag does not match key");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind escape_key_decoder_cursor_unit ekd_checker u_ekd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_key_code   (out_key_code),
  .out_cursor_col (out_cursor_col),
  .out_cursor_row (out_cursor_row),
  .out_quit       (out_quit)
);
